>>> rtl/core/eflba_pkg.sv
package eflba_pkg;

   // Field widths
   localparam int ActionW    = 2;
   localparam int OffsetW    = 16;
   localparam int StatusW    = 2;
   localparam int SizeW      = 9;
   localparam int CountW     = 8;
   localparam int CsrAddrW   = 1;
   localparam int CsrDataW   = 9;
   localparam int ReqTdataW  = 16;
   localparam int ReqTuserW  = 2;
   localparam int RspTdataW  = 24;
   localparam int RspTuserW  = 2;

   localparam int MaxBlocksDefault = 255;

   // Actions
   localparam logic [ActionW-1:0] ACT_INIT  = 2'd0;
   localparam logic [ActionW-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ActionW-1:0] ACT_FREE  = 2'd2;

   // Statuses
   localparam logic [StatusW-1:0] ST_OK         = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY      = 2'd1;
   localparam logic [StatusW-1:0] ST_MISALIGNED = 2'd2;
   localparam logic [StatusW-1:0] ST_RANGE      = 2'd3;

   // Register indexes
   localparam logic [CsrAddrW-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CsrAddrW-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic [SizeW-1:0]  BlockSizeReset  = 9'd8;
   localparam logic [CountW-1:0] BlockCountReset = 8'd255;

   typedef struct packed {
      logic               done;
      logic [OffsetW-1:0] quotient;
      logic [SizeW-1:0]   remainder;
   } div_result_type;

endpackage

>>> rtl/core/embedded_free_list_block_allocator.sv
// Fixed-size block allocator: a singly linked free list over up to MAX_BLOCKS
// blocks, kept in an on-chip link memory (one 8-bit next index per block) plus
// head and free-count registers. Send an item with action init (0), allocate
// (1) or free (2, offset in bytes); every item returns exactly one result item
// with a status, the allocated byte offset and the free count after the item.
// The block handles one item at a time. Allocate reads the link memory once
// and then commits. Free waits on the 16-step bit-serial divider that turns
// the byte offset into a block index and checks alignment. Init writes one
// link entry per cycle through the single memory write port. An allocate on
// an empty list and the unused action go straight to commit.
// A finished result sits in an output register, so the next item is accepted
// while it waits; the block only holds its commit when that register is full.
// Links are undefined after reset: run init before allocating (allocation
// reports no free block until then, unless a block was freed). Write
// block_size and block_count only while no item is in flight. Double frees
// are not detected.
module embedded_free_list_block_allocator #(
   parameter int MAX_BLOCKS = eflba_pkg::MaxBlocksDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = offset[15:0]; tuser = action[1:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [eflba_pkg::ReqTdataW-1:0]    req_tdata,
   input  logic [eflba_pkg::ReqTuserW-1:0]    req_tuser,
   // response: tdata = block_offset[15:0], free_blocks[23:16]; tuser = status[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [eflba_pkg::RspTdataW-1:0]    rsp_tdata,
   output logic [eflba_pkg::RspTuserW-1:0]    rsp_tuser,
   // configuration writes
   input  logic                               csr_we,
   input  logic [eflba_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [eflba_pkg::CsrDataW-1:0]     csr_wdata
);
   import eflba_pkg::*;

   localparam int IdxW = $clog2(MAX_BLOCKS);
   localparam logic [CountW-1:0] MaxBlk = CountW'(MAX_BLOCKS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [ActionW-1:0]  act_ff, act_in;
   logic [SizeW-1:0]    size_ff;
   logic [CountW-1:0]   count_ff;
   logic [CountW-1:0]   head_ff, head_in;
   logic [CountW-1:0]   free_ff, free_in;
   logic [CountW-1:0]   init_idx_ff, init_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0]  rsp_status_ff, rsp_status_in;
   logic [OffsetW-1:0]  rsp_off_ff, rsp_off_in;
   logic [CountW-1:0]   rsp_free_ff, rsp_free_in;

   logic [SizeW-1:0]    eff_size;
   logic [CountW-1:0]   eff_count;
   logic                accept;
   logic                commit;
   logic [SizeW+CountW-1:0] product;

   logic                mem_we;
   logic [IdxW-1:0]     mem_waddr;
   logic [CountW-1:0]   mem_wdata;
   logic                mem_re;
   logic [CountW-1:0]   mem_rdata;

   logic                div_start;
   div_result_type      div_res;

   logic [StatusW-1:0]  fin_status;
   logic [OffsetW-1:0]  fin_off;
   logic [CountW-1:0]   fin_head;
   logic [CountW-1:0]   fin_free;
   logic                fin_link_we;

   // a size of zero acts as one; a count beyond the store is clipped
   assign eff_size  = (size_ff == '0) ? SizeW'(1) : size_ff;
   assign eff_count = (count_ff > MaxBlk) ? MaxBlk : count_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign div_start  = accept && (req_tuser == ACT_FREE);
   assign product    = head_ff * eff_size;

   eflba_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[OffsetW-1:0]),
      .divisor  (eff_size),
      .result   (div_res)
   );

   eflba_link_mem #(
      .Depth (MAX_BLOCKS),
      .AddrW (IdxW)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (head_ff[IdxW-1:0]),
      .rd_data (mem_rdata)
   );

   // result and state update for the item in the finish stage
   always_comb begin
      fin_status  = ST_OK;
      fin_off     = '0;
      fin_head    = head_ff;
      fin_free    = free_ff;
      fin_link_we = 1'b0;
      case (act_ff)
         ACT_INIT: begin
            fin_head = '0;
            fin_free = eff_count;
         end
         ACT_ALLOC: begin
            if (free_ff == '0) begin
               fin_status = ST_EMPTY;
            end else begin
               fin_off  = product[OffsetW-1:0];
               // a head past the store links to block zero
               fin_head = (head_ff < MaxBlk) ? mem_rdata : '0;
               fin_free = free_ff - 1'b1;
            end
         end
         ACT_FREE: begin
            if (div_res.remainder != '0) begin
               fin_status = ST_MISALIGNED;
            end else if (div_res.quotient >= {{(OffsetW-CountW){1'b0}}, eff_count}) begin
               fin_status = ST_RANGE;
            end else begin
               fin_link_we = 1'b1;
               fin_head    = div_res.quotient[CountW-1:0];
               fin_free    = (free_ff == '1) ? free_ff : free_ff + 1'b1;
            end
         end
         default: begin
            fin_status = ST_OK;
         end
      endcase
   end

   // link memory port: init sweep or the push of a freed block
   always_comb begin
      mem_re = (state_ff == S_ALLOC);
      if (state_ff == S_INIT) begin
         mem_we    = 1'b1;
         mem_waddr = init_idx_ff[IdxW-1:0];
         mem_wdata = init_idx_ff + 1'b1;
      end else begin
         mem_we    = commit && fin_link_we;
         mem_waddr = div_res.quotient[IdxW-1:0];
         mem_wdata = head_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      init_idx_in   = init_idx_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_free_in   = rsp_free_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in      = req_tuser;
               init_idx_in = '0;
               case (req_tuser)
                  ACT_INIT:  state_in = (eff_count == '0) ? S_FINISH : S_INIT;
                  ACT_ALLOC: state_in = (free_ff == '0) ? S_FINISH : S_ALLOC;
                  ACT_FREE:  state_in = S_DIV;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_INIT: begin
            init_idx_in = init_idx_ff + 1'b1;
            if (init_idx_ff == eff_count - 1'b1) begin
               state_in = S_FINISH;
            end
         end
         S_ALLOC: begin
            state_in = S_FINISH;
         end
         S_DIV: begin
            if (div_res.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free, then commit
            if (commit) begin
               head_in       = fin_head;
               free_in       = fin_free;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fin_status;
               rsp_off_in    = fin_off;
               rsp_free_in   = fin_free;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= BlockSizeReset;
         count_ff     <= BlockCountReset;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_BLOCK_SIZE:  size_ff  <= csr_wdata[SizeW-1:0];
               CSR_BLOCK_COUNT: count_ff <= csr_wdata[CountW-1:0];
               default: begin
               end
            endcase
         end
      end
      act_ff        <= act_in;
      init_idx_ff   <= init_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_free_ff, rsp_off_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> rtl/core/eflba_divider.sv
module eflba_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [eflba_pkg::OffsetW-1:0]   dividend,
   input  logic [eflba_pkg::SizeW-1:0]     divisor,
   output eflba_pkg::div_result_type       result
);
   import eflba_pkg::*;

   localparam int StepW = $clog2(OffsetW);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [OffsetW-1:0]   quo_ff, quo_in;
   logic [SizeW-1:0]     rem_ff, rem_in;
   logic [SizeW-1:0]     div_ff, div_in;
   logic [SizeW:0]       trial;
   logic                 fits;

   // one quotient bit per cycle, dividend shifts out as the quotient shifts in
   always_comb begin
      trial   = {rem_ff, quo_ff[OffsetW-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? SizeW'(trial - {1'b0, div_ff}) : trial[SizeW-1:0];
         quo_in  = {quo_ff[OffsetW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(OffsetW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

>>> rtl/core/eflba_link_mem.sv
module eflba_link_mem #(
   parameter int Depth = eflba_pkg::MaxBlocksDefault,
   parameter int AddrW = $clog2(eflba_pkg::MaxBlocksDefault)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrW-1:0]              wr_addr,
   input  logic [eflba_pkg::CountW-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AddrW-1:0]              rd_addr,
   output logic [eflba_pkg::CountW-1:0]  rd_data
);
   import eflba_pkg::*;

   logic [CountW-1:0] mem [Depth];
   logic [CountW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/block_allocation_checker.sv
`timescale 1ns / 100ps
module block_allocation_checker (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = offset[15:0]; tuser = action[1:0]
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [eflba_pkg::ReqTdataW-1:0] req_tdata,
   input  logic [eflba_pkg::ReqTuserW-1:0] req_tuser,
   // response: tdata = block_offset[15:0], free_blocks[23:16]; tuser = status[1:0]
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [eflba_pkg::RspTdataW-1:0] rsp_tdata,
   input  logic [eflba_pkg::RspTuserW-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic [eflba_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [eflba_pkg::CsrDataW-1:0]  csr_wdata,
   output int                              mismatch_total,
   output int                              responses_owed
);
   import eflba_pkg::*;

   localparam int Capacity   = MaxBlocksDefault;
   localparam int MaxReports = 10;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [OffsetW-1:0] block_offset;
      logic [CountW-1:0]  free_blocks;
   } alloc_response_type;

   logic [CountW-1:0]  link_mem [Capacity];
   logic [CountW-1:0]  head_blk;
   logic [CountW-1:0]  free_cnt;
   logic [CountW-1:0]  blk_count;
   logic [SizeW-1:0]   blk_size;
   alloc_response_type owed_responses [$];
   int                 faults = 0;

   // Apply one request to the shadow free list and return the response it owes.
   function automatic alloc_response_type apply_allocator_item(input logic [ActionW-1:0] act,
                                                               input logic [OffsetW-1:0] ofs);
      alloc_response_type rsp;
      int unsigned        sz;
      int unsigned        lim;
      int unsigned        idx;
      int unsigned        prod;
      int unsigned        i;
      sz  = (blk_size == 0) ? 1 : blk_size;
      lim = (blk_count > Capacity) ? Capacity : blk_count;
      rsp.status       = ST_OK;
      rsp.block_offset = '0;
      case (act)
         ACT_INIT: begin
            for (i = 0; i < lim; i++) link_mem[i] = CountW'(i + 1);
            head_blk = '0;
            free_cnt = CountW'(lim);
         end
         ACT_ALLOC: begin
            if (free_cnt == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               prod = head_blk * sz;
               rsp.block_offset = prod[OffsetW-1:0];
               head_blk = (head_blk < Capacity) ? link_mem[head_blk] : '0;
               free_cnt = free_cnt - 1'b1;
            end
         end
         ACT_FREE: begin
            idx = ofs / sz;
            if (ofs % sz != 0) begin
               rsp.status = ST_MISALIGNED;
            end else if (idx >= lim) begin
               rsp.status = ST_RANGE;
            end else begin
               link_mem[idx] = head_blk;
               head_blk = idx[CountW-1:0];
               if (free_cnt != '1) free_cnt = free_cnt + 1'b1;
            end
         end
         default: ;
      endcase
      rsp.free_blocks = free_cnt;
      return rsp;
   endfunction

   always @(posedge clock) begin
      alloc_response_type seen;
      alloc_response_type want;
      int unsigned        k;
      if (reset) begin
         for (k = 0; k < Capacity; k++) link_mem[k] = '0;
         head_blk  = '0;
         free_cnt  = '0;
         blk_size  = BlockSizeReset;
         blk_count = BlockCountReset;
         owed_responses.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BLOCK_SIZE:  blk_size = csr_wdata[SizeW-1:0];
               CSR_BLOCK_COUNT: blk_count = csr_wdata[CountW-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.status       = rsp_tuser[StatusW-1:0];
            seen.block_offset = rsp_tdata[OffsetW-1:0];
            seen.free_blocks  = rsp_tdata[OffsetW+CountW-1:OffsetW];
            if (owed_responses.size() == 0) begin
               faults++;
               if (faults <= MaxReports)
                  $display("%0t: response with none owed: status=%0d offset=%0h free=%0d",
                           $realtime, seen.status, seen.block_offset, seen.free_blocks);
            end else begin
               want = owed_responses.pop_front();
               if (seen !== want) begin
                  faults++;
                  if (faults <= MaxReports) begin
                     $write("%0t: mismatch: expected status=%0d offset=%0h free=%0d",
                            $realtime, want.status, want.block_offset, want.free_blocks);
                     $display(", got status=%0d offset=%0h free=%0d",
                              seen.status, seen.block_offset, seen.free_blocks);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            owed_responses.push_back(apply_allocator_item(req_tuser[ActionW-1:0],
                                                          req_tdata[OffsetW-1:0]));
      end
      responses_owed <= owed_responses.size();
      mismatch_total <= faults;
   end

endmodule

>>> sim/tb_embedded_free_list_block_allocator.sv
`timescale 1ns / 100ps
module tb_embedded_free_list_block_allocator;
   import eflba_pkg::*;

   // Action code the block decodes as a no-op.
   localparam logic [ActionW-1:0] ACT_NONE = 2'd3;

   localparam int Segments        = 12;
   localparam int ItemsPerSegment = 167;
   // No item moving on either channel for this long means the block hung; the
   // limit covers the longest init plus a long receiver stall on top of it.
   localparam int StallLimit      = 5000;
   // Quiet time at the end to catch stray responses; covers the longest init.
   localparam int SettleCycles    = 300;

   // Settings per random segment: extremes of both registers, including the
   // out-of-range sizes (0 and above 256) and an empty block count.
   localparam int SizePlan  [Segments] = '{8, 1, 256, 0, 511, 257, 3, 16, 5, 128, 2, 64};
   localparam int CountPlan [Segments] = '{255, 1, 0, 255, 255, 7, 2, 255, 33, 10, 64, 3};

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqTdataW-1:0] req_tdata  = '0;   // offset[15:0]
   logic [ReqTuserW-1:0] req_tuser  = '0;   // action[1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspTdataW-1:0] rsp_tdata;         // block_offset[15:0], free_blocks[23:16]
   logic [RspTuserW-1:0] rsp_tuser;         // status[1:0]
   logic                 csr_we     = 1'b0;
   logic [CsrAddrW-1:0]  csr_addr   = '0;
   logic [CsrDataW-1:0]  csr_wdata  = '0;

   int                   send_idle_pct = 13;
   int                   recv_idle_pct = 87;
   int                   stall_cycles  = 0;
   int                   mismatch_total;
   int                   responses_owed;
   logic [SizeW-1:0]     cur_size  = BlockSizeReset;
   logic [CountW-1:0]    cur_count = BlockCountReset;

   always #5 clock = ~clock;

   embedded_free_list_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   block_allocation_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .responses_owed (responses_owed)
   );

   // Stall the response side at random; a zero percentage keeps it always ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Count cycles in which neither channel moves an item; end the run on a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == StallLimit) begin
         $display("** embedded_free_list_block_allocator: FAILED **");
         $finish;
      end
   end

   // Present one item and hold it until accepted. Valid is only lowered inside
   // the gap loop, so back-to-back items never drop and re-raise valid in one step.
   task automatic send_item(input logic [ActionW-1:0] act, input logic [OffsetW-1:0] ofs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= ofs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and hold off until every owed response has come back.
   // The first edge lets the owed count see the last accepted item.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (responses_owed != 0);
   endtask

   // Write both registers on consecutive edges; the block is idle here.
   task automatic write_settings(input logic [SizeW-1:0] sz, input logic [CountW-1:0] cnt);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_BLOCK_SIZE;
      csr_wdata <= sz;
      @(posedge clock);
      csr_addr  <= CSR_BLOCK_COUNT;
      csr_wdata <= {1'b0, cnt};
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_size  = sz;
      cur_count = cnt;
   endtask

   // Mostly well-formed traffic: allocations and frees of aligned in-range
   // blocks, biased toward draining or refilling the list. The rest is noise:
   // misaligned and out-of-range frees, re-inits, the no-op action, raw items.
   task automatic issue_random_item(input bit alloc_heavy);
      int unsigned        roll;
      int unsigned        eff_sz;
      int unsigned        idx;
      logic [ActionW-1:0] act;
      logic [OffsetW-1:0] ofs;
      eff_sz = (cur_size == 0) ? 1 : cur_size;
      idx    = $urandom_range((cur_count == 0) ? 0 : cur_count - 1);
      ofs    = OffsetW'($urandom_range(65535));
      roll   = $urandom_range(99);
      if (roll < 4) begin
         act = ACT_INIT;
      end else if (roll < (alloc_heavy ? 60 : 30)) begin
         act = ACT_ALLOC;
      end else if (roll < 84) begin
         act = ACT_FREE;
         ofs = OffsetW'(idx * eff_sz);
      end else if (roll < 89) begin
         act = ACT_FREE;
         ofs = OffsetW'(idx * eff_sz + $urandom_range(eff_sz - 1));
      end else if (roll < 93) begin
         act = ACT_FREE;
         ofs = OffsetW'((cur_count + $urandom_range(15)) * eff_sz);
      end else if (roll < 96) begin
         act = ACT_NONE;
      end else begin
         act = ActionW'($urandom_range(3));
      end
      send_item(act, ofs);
   endtask

   initial begin
      int seg;
      int n;
      bit heavy;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset settings (block size 8, block count 255).
      // Before init: allocation fails; a free still links its block in.
      send_item(ACT_ALLOC, 16'h0000);
      send_item(ACT_FREE,  16'h0000);
      send_item(ACT_ALLOC, 16'h0000);
      send_item(ACT_ALLOC, 16'h0000);
      // Unused action does nothing.
      send_item(ACT_NONE,  16'hFFFF);
      // Full init links every entry, so no later read hits an unwritten link.
      send_item(ACT_INIT,  16'hFFFF);
      send_item(ACT_ALLOC, 16'h0000);
      send_item(ACT_ALLOC, 16'h0000);
      send_item(ACT_FREE,  16'h0000);
      // Misaligned; then misaligned and out of range at once (misalignment wins).
      send_item(ACT_FREE,  16'h0003);
      send_item(ACT_FREE,  16'hFFFF);
      // Aligned but beyond the block count: far out, then just past the end.
      send_item(ACT_FREE,  16'hFFF8);
      send_item(ACT_FREE,  16'd2040);
      // Last block in range fills the count; one more free saturates it.
      send_item(ACT_FREE,  16'd2032);
      send_item(ACT_FREE,  16'd8);
      send_item(ACT_INIT,  16'h0000);

      for (seg = 0; seg < Segments; seg++) begin
         // Swap the idle pattern a third of the way in, then stop idling.
         if (seg == Segments / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 13;
         end else if (seg == 2 * Segments / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Pause the sender until the block has answered everything, then reconfigure.
         settle_idle();
         write_settings(SizeW'(SizePlan[seg]), CountW'(CountPlan[seg]));
         send_item(ACT_INIT, OffsetW'($urandom_range(65535)));
         for (n = 0; n < ItemsPerSegment; n++) begin
            if (n % 25 == 0) heavy = 1'($urandom_range(1));
            issue_random_item(heavy);
         end
      end

      settle_idle();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("** embedded_free_list_block_allocator: PASSED **");
      end else begin
         $display("** embedded_free_list_block_allocator: FAILED **");
      end
      $finish;
   end

endmodule

>>> embedded_free_list_block_allocator.f
rtl/core/eflba_pkg.sv
rtl/core/eflba_divider.sv
rtl/core/eflba_link_mem.sv
rtl/core/embedded_free_list_block_allocator.sv
sim/block_allocation_checker.sv
sim/tb_embedded_free_list_block_allocator.sv
